@@ rtl/srfp_pkg.sv @@
package srfp_pkg;

	localparam logic [7:0] HDR_FIRST  = 8'hFF;
	localparam logic [7:0] HDR_SECOND = 8'hF5;

	localparam int unsigned IN_TDATA_W  = 8;
	localparam int unsigned OUT_TDATA_W = 40;

	typedef enum logic [2:0] {
		PH_HEAD1   = 3'd0,
		PH_HEAD2   = 3'd1,
		PH_ID      = 3'd2,
		PH_LEN     = 3'd3,
		PH_CONTENT = 3'd4,
		PH_CHECK   = 3'd5
	} phase_t;

	typedef struct packed {
		logic [7:0] frame_length;
		logic [7:0] frame_id;
		logic       frame_bad;
		logic       frame_good;
		logic [7:0] content_index;
		logic [7:0] content_byte;
		logic       content_valid;
	} result_t;

endpackage

@@ rtl/srfp_parse.sv @@
module srfp_parse (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [7:0]             rx_byte,
	output srfp_pkg::result_t      result
);

	srfp_pkg::phase_t phase_q, phase_d;
	logic [7:0] id_q, id_d;
	logic [7:0] len_q, len_d;
	logic [7:0] count_q, count_d;
	logic [7:0] sum_q, sum_d;
	logic [8:0] taken;
	logic [8:0] last_taken;

	assign taken      = {1'b0, count_q} + 9'd1;
	assign last_taken = {1'b0, len_q} - 9'd1;

	always_comb begin
		phase_d = phase_q;
		id_d    = id_q;
		len_d   = len_q;
		count_d = count_q;
		sum_d   = sum_q;
		unique case (phase_q)
			srfp_pkg::PH_HEAD1: begin
				phase_d = (rx_byte == srfp_pkg::HDR_FIRST) ? srfp_pkg::PH_HEAD2
					: srfp_pkg::PH_HEAD1;
			end
			srfp_pkg::PH_HEAD2: begin
				phase_d = (rx_byte == srfp_pkg::HDR_SECOND) ? srfp_pkg::PH_ID
					: srfp_pkg::PH_HEAD1;
			end
			srfp_pkg::PH_ID: begin
				id_d    = rx_byte;
				len_d   = 8'd0;
				sum_d   = rx_byte;
				phase_d = srfp_pkg::PH_LEN;
			end
			srfp_pkg::PH_LEN: begin
				len_d   = rx_byte;
				sum_d   = sum_q + rx_byte;
				count_d = 8'd0;
				phase_d = srfp_pkg::PH_CONTENT;
			end
			srfp_pkg::PH_CONTENT: begin
				sum_d   = sum_q + rx_byte;
				count_d = taken[7:0];
				if (len_q < 8'd2 || taken >= last_taken) begin
					phase_d = srfp_pkg::PH_CHECK;
				end
			end
			srfp_pkg::PH_CHECK: begin
				phase_d = srfp_pkg::PH_HEAD1;
			end
			default: begin
				phase_d = srfp_pkg::PH_HEAD1;
			end
		endcase
	end

	always_comb begin
		result               = '0;
		result.frame_id      = id_d;
		result.frame_length  = len_d;
		unique case (phase_q)
			srfp_pkg::PH_CONTENT: begin
				result.content_valid = 1'b1;
				result.content_byte  = rx_byte;
				result.content_index = count_q;
			end
			srfp_pkg::PH_CHECK: begin
				result.frame_good = (rx_byte == ~sum_q);
				result.frame_bad  = (rx_byte != ~sum_q);
			end
			default: begin
				result.content_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= srfp_pkg::PH_HEAD1;
			id_q    <= 8'd0;
			len_q   <= 8'd0;
			count_q <= 8'd0;
			sum_q   <= 8'd0;
		end else if (step) begin
			phase_q <= phase_d;
			id_q    <= id_d;
			len_q   <= len_d;
			count_q <= count_d;
			sum_q   <= sum_d;
		end
	end

endmodule

@@ rtl/servo_reply_frame_parser.sv @@
// Parser for servo bus reply frames, fed one received byte per word.
// The slave channel takes one byte per word in s_axis_tdata. The master
// channel returns exactly one result word for every byte taken, carrying
// content byte and index flags, good or bad checksum flags, and the id and
// length of the current frame.
// Each byte passes an input register and then the parse logic into an
// output register, which holds its result word until the word is taken.
// One byte per cycle is sustained while the receiver does not stall; the
// frame state registers close their update loop through the parse logic.
// Reset clears the valid flags of both registers and returns the parser to
// the hunt for the first header byte with id, length, count and sum at zero.
// When the receiver stalls, the output register holds its word, the input
// register fills, and s_axis_tready drops until the output word is taken;
// no word is lost or repeated.
module servo_reply_frame_parser (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// [7:0] rx_byte
	input  logic [srfp_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// [0] content_valid, [8:1] content_byte, [16:9] content_index,
	// [17] frame_good, [18] frame_bad, [26:19] frame_id,
	// [34:27] frame_length, [39:35] zero
	output logic [srfp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              valid_s2;
	srfp_pkg::result_t result_s2;
	srfp_pkg::result_t result;
	logic              advance;

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	srfp_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata[7:0];
		end
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {{(srfp_pkg::OUT_TDATA_W - $bits(srfp_pkg::result_t)){1'b0}},
		result_s2};

endmodule
